// ----- rtl/ttoi_pkg.sv -----
// Shared constants and types for the text-to-integer parser.
package ttoi_pkg;

	localparam int VALUE_WIDTH = 64;
	localparam int COUNT_WIDTH = 16;
	localparam int RADIX_WIDTH = 6;
	localparam int CHAR_WIDTH  = 8;
	localparam int DIGIT_WIDTH = 6;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
	localparam logic [RADIX_WIDTH-1:0] RADIX_RESET = RADIX_WIDTH'(10);
	localparam logic [RADIX_WIDTH-1:0] BASE_AUTO = RADIX_WIDTH'(0);
	localparam logic [RADIX_WIDTH-1:0] BASE_ONE = RADIX_WIDTH'(1);
	localparam logic [RADIX_WIDTH-1:0] BASE_OCT = RADIX_WIDTH'(8);
	localparam logic [RADIX_WIDTH-1:0] BASE_DEC = RADIX_WIDTH'(10);
	localparam logic [RADIX_WIDTH-1:0] BASE_HEX = RADIX_WIDTH'(16);
	localparam logic [RADIX_WIDTH-1:0] BASE_MAX = RADIX_WIDTH'(36);

	localparam logic [CHAR_WIDTH-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_WIDTH-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_WIDTH-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_WIDTH-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_WIDTH-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_WIDTH-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_WIDTH-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_WIDTH-1:0] CH_UA    = 8'h41;
	localparam logic [CHAR_WIDTH-1:0] CH_UZ    = 8'h5A;
	localparam logic [CHAR_WIDTH-1:0] CH_LA    = 8'h61;
	localparam logic [CHAR_WIDTH-1:0] CH_LZ    = 8'h7A;
	localparam logic [CHAR_WIDTH-1:0] CH_LX    = 8'h78;
	localparam logic [CHAR_WIDTH-1:0] CH_UX    = 8'h58;
	localparam logic [DIGIT_WIDTH-1:0] LETTER_OFFSET = DIGIT_WIDTH'(10);

	typedef struct packed {
		logic                   ws;
		logic                   sign;
		logic                   minus;
		logic                   zero;
		logic                   ex;
		logic                   digit_ok;
		logic [DIGIT_WIDTH-1:0] digit;
	} char_class_t;

endpackage

// ----- rtl/ttoi_if.sv -----
// Channel interfaces: radix write, character input, parse result.
interface ttoi_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [ttoi_pkg::RADIX_WIDTH-1:0]   radix;

	modport source (output valid, output radix, input ready);
	modport sink (input valid, input radix, output ready);
endinterface

interface ttoi_in_if;
	logic                               valid;
	logic                               ready;
	logic [ttoi_pkg::CHAR_WIDTH-1:0]    ch;
	logic                               first;

	modport source (output valid, output ch, output first, input ready);
	modport sink (input valid, input ch, input first, output ready);
endinterface

interface ttoi_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [ttoi_pkg::VALUE_WIDTH-1:0] value;
	logic [ttoi_pkg::COUNT_WIDTH-1:0]       end_offset;
	logic                                   bad_base;
	logic                                   overflow;

	modport source (output valid, output value, output end_offset, output bad_base,
		output overflow, input ready);
	modport sink (input valid, input value, input end_offset, input bad_base,
		input overflow, output ready);
endinterface

// ----- rtl/ttoi_classify.sv -----
// Character classifier: whitespace, sign, prefix letters and digit value.
module ttoi_classify (
	input  logic [ttoi_pkg::CHAR_WIDTH-1:0] ch,
	output ttoi_pkg::char_class_t           cls
);

	always_comb begin
		cls.ws    = (ch == ttoi_pkg::CH_SPACE) ||
			(ch inside {[ttoi_pkg::CH_TAB:ttoi_pkg::CH_CR]});
		cls.sign  = (ch == ttoi_pkg::CH_PLUS) || (ch == ttoi_pkg::CH_MINUS);
		cls.minus = (ch == ttoi_pkg::CH_MINUS);
		cls.zero  = (ch == ttoi_pkg::CH_0);
		cls.ex    = (ch == ttoi_pkg::CH_LX) || (ch == ttoi_pkg::CH_UX);
		cls.digit_ok = 1'b1;
		cls.digit    = '0;
		if (ch inside {[ttoi_pkg::CH_0:ttoi_pkg::CH_9]}) begin
			cls.digit = ttoi_pkg::DIGIT_WIDTH'(ch - ttoi_pkg::CH_0);
		end else if (ch inside {[ttoi_pkg::CH_LA:ttoi_pkg::CH_LZ]}) begin
			cls.digit = ttoi_pkg::DIGIT_WIDTH'(ch - ttoi_pkg::CH_LA) +
				ttoi_pkg::LETTER_OFFSET;
		end else if (ch inside {[ttoi_pkg::CH_UA:ttoi_pkg::CH_UZ]}) begin
			cls.digit = ttoi_pkg::DIGIT_WIDTH'(ch - ttoi_pkg::CH_UA) +
				ttoi_pkg::LETTER_OFFSET;
		end else begin
			cls.digit_ok = 1'b0;
		end
	end

endmodule

// ----- rtl/ttoi_mac.sv -----
// Multiply-accumulate for one digit: acc * base + digit with carry-out detect.
module ttoi_mac (
	input  logic [ttoi_pkg::VALUE_WIDTH-1:0] acc,
	input  logic [ttoi_pkg::RADIX_WIDTH-1:0] base,
	input  logic [ttoi_pkg::DIGIT_WIDTH-1:0] digit,
	output logic [ttoi_pkg::VALUE_WIDTH-1:0] sum,
	output logic                             carry
);

	localparam int FULL_WIDTH = ttoi_pkg::VALUE_WIDTH + ttoi_pkg::RADIX_WIDTH;

	logic [FULL_WIDTH-1:0] full;

	always_comb begin
		full  = FULL_WIDTH'(acc) * FULL_WIDTH'(base) + FULL_WIDTH'(digit);
		sum   = full[ttoi_pkg::VALUE_WIDTH-1:0];
		carry = |full[FULL_WIDTH-1:ttoi_pkg::VALUE_WIDTH];
	end

endmodule

// ----- rtl/text_to_integer_parser.sv -----
// Streaming strtol-style parser: one character per beat, at most one result per string.
// A beat is registered in the input register on accept, then stepped into the parse state
// and the result register once no unaccepted result is held.
// Throughput: one character per cycle; the 64x6 digit multiply-accumulate sets the cycle.
// Input stalls only while a beat waits in the input register behind a held result.
// Reset: radix returns to 10, parser waits for a character flagged as first.
module text_to_integer_parser (
	input  logic       clk,
	input  logic       arst_n,
	ttoi_cfg_if.sink   cfg,
	ttoi_in_if.sink    chars,
	ttoi_out_if.source result
);

	localparam logic [2:0] PH_DONE   = 3'd0;
	localparam logic [2:0] PH_LEAD   = 3'd1;
	localparam logic [2:0] PH_SIGNED = 3'd2;
	localparam logic [2:0] PH_ZERO   = 3'd3;
	localparam logic [2:0] PH_XSEEN  = 3'd4;
	localparam logic [2:0] PH_DIGITS = 3'd5;

	localparam int VW = ttoi_pkg::VALUE_WIDTH;
	localparam int CW = ttoi_pkg::COUNT_WIDTH;
	localparam int RW = ttoi_pkg::RADIX_WIDTH;

	logic [RW-1:0] radix_q;

	logic                           valid_s1;
	logic [ttoi_pkg::CHAR_WIDTH-1:0] ch_s1;
	logic                           first_s1;

	logic [2:0]    phase_q;
	logic          neg_q;
	logic [VW-1:0] acc_q;
	logic [RW-1:0] base_q;
	logic [CW-1:0] count_q;
	logic          ovf_q;

	logic          out_valid_q;
	logic [VW-1:0] out_value_q;
	logic [CW-1:0] out_end_q;
	logic          out_bad_q;
	logic          out_ovf_q;

	logic advance;
	logic step_go;

	ttoi_pkg::char_class_t cls;

	logic [2:0]    ph;
	logic          neg;
	logic [VW-1:0] acc;
	logic [RW-1:0] base;
	logic [CW-1:0] cnt;
	logic          ovf;
	logic [CW-1:0] cnt_inc;
	logic [RW-1:0] dbase;
	logic          d_ok;
	logic [VW-1:0] mac_sum;
	logic          mac_carry;
	logic          in_digits;
	logic          bad;

	logic [2:0]    ph_n;
	logic          neg_n;
	logic [VW-1:0] acc_n;
	logic [RW-1:0] base_n;
	logic [CW-1:0] cnt_n;
	logic          ovf_n;

	logic          emit;
	logic [VW-1:0] e_value;
	logic [CW-1:0] e_end;
	logic          e_bad;
	logic          e_ovf;

	ttoi_classify u_classify (
		.ch  (ch_s1),
		.cls (cls)
	);

	ttoi_mac u_mac (
		.acc   (acc),
		.base  (dbase),
		.digit (cls.digit),
		.sum   (mac_sum),
		.carry (mac_carry)
	);

	assign advance      = !out_valid_q || result.ready;
	assign step_go      = valid_s1 && advance;
	assign chars.ready  = !valid_s1 || advance;
	assign cfg.ready    = 1'b1;

	assign result.valid      = out_valid_q;
	assign result.value      = out_value_q;
	assign result.end_offset = out_end_q;
	assign result.bad_base   = out_bad_q;
	assign result.overflow   = out_ovf_q;

	always_comb begin
		// a first beat restarts the parse before it is stepped
		ph   = first_s1 ? PH_LEAD : phase_q;
		neg  = first_s1 ? 1'b0 : neg_q;
		acc  = first_s1 ? '0 : acc_q;
		base = first_s1 ? radix_q : base_q;
		cnt  = first_s1 ? '0 : count_q;
		ovf  = first_s1 ? 1'b0 : ovf_q;

		cnt_inc   = (cnt == ttoi_pkg::COUNT_MAX) ? cnt : cnt + 1'b1;
		dbase     = (base == ttoi_pkg::BASE_AUTO) ?
			((ph == PH_ZERO) ? ttoi_pkg::BASE_OCT : ttoi_pkg::BASE_DEC) : base;
		d_ok      = cls.digit_ok && (cls.digit < dbase);
		in_digits = ph inside {PH_ZERO, PH_XSEEN, PH_DIGITS};
		bad       = (base == ttoi_pkg::BASE_ONE) || (base > ttoi_pkg::BASE_MAX);

		ph_n   = ph;
		neg_n  = neg;
		acc_n  = acc;
		base_n = base;
		cnt_n  = cnt;
		ovf_n  = ovf;

		emit    = 1'b0;
		e_value = '0;
		e_end   = '0;
		e_bad   = 1'b0;
		e_ovf   = 1'b0;

		case (ph)
			PH_LEAD, PH_SIGNED, PH_ZERO, PH_XSEEN, PH_DIGITS: begin
				if (ph == PH_LEAD && cls.ws) begin
					cnt_n = cnt_inc;
				end else if (ph == PH_LEAD && cls.sign) begin
					neg_n = cls.minus;
					cnt_n = cnt_inc;
					ph_n  = PH_SIGNED;
				end else if ((ph inside {PH_LEAD, PH_SIGNED}) && bad) begin
					emit  = 1'b1;
					e_bad = 1'b1;
					ph_n  = PH_DONE;
				end else if ((ph inside {PH_LEAD, PH_SIGNED}) && cls.zero &&
					(base inside {ttoi_pkg::BASE_AUTO, ttoi_pkg::BASE_HEX})) begin
					cnt_n = cnt_inc;
					ph_n  = PH_ZERO;
				end else if (ph == PH_ZERO && cls.ex) begin
					cnt_n  = cnt_inc;
					base_n = ttoi_pkg::BASE_HEX;
					ph_n   = PH_XSEEN;
				end else if (ph == PH_XSEEN && !d_ok) begin
					// drop the 'x': only the leading zero counts
					emit  = 1'b1;
					e_end = (cnt == ttoi_pkg::COUNT_MAX) ? cnt : cnt - 1'b1;
					ph_n  = PH_DONE;
				end else begin
					base_n = dbase;
					if (d_ok) begin
						acc_n = mac_sum;
						ovf_n = ovf || mac_carry;
						cnt_n = cnt_inc;
						ph_n  = PH_DIGITS;
					end else begin
						emit = 1'b1;
						ph_n = PH_DONE;
						if (in_digits) begin
							e_value = neg ? (VW'(0) - acc) : acc;
							e_end   = cnt;
							e_ovf   = ovf;
						end
					end
				end
			end
			default: begin
				ph_n = PH_DONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q     <= ttoi_pkg::RADIX_RESET;
			valid_s1    <= 1'b0;
			phase_q     <= PH_DONE;
			neg_q       <= 1'b0;
			acc_q       <= '0;
			base_q      <= '0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				radix_q <= cfg.radix;
			end
			if (chars.valid && chars.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (step_go) begin
				phase_q <= ph_n;
				neg_q   <= neg_n;
				acc_q   <= acc_n;
				base_q  <= base_n;
				count_q <= cnt_n;
				ovf_q   <= ovf_n;
			end
			if (advance) begin
				out_valid_q <= valid_s1 && emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			ch_s1    <= chars.ch;
			first_s1 <= chars.first;
		end
		if (step_go && emit) begin
			out_value_q <= e_value;
			out_end_q   <= e_end;
			out_bad_q   <= e_bad;
			out_ovf_q   <= e_ovf;
		end
	end

	a_bad_base_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.bad_base |->
			result.value == '0 && result.end_offset == '0 && !result.overflow)
		else $error("bad base result carries nonzero fields");

	a_done_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		step_go && emit |=> phase_q == PH_DONE)
		else $error("parser not done after emitting a result");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!chars.ready |-> valid_s1 && out_valid_q && !result.ready)
		else $error("input stalled without a held result");

	a_prefix_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ZERO || phase_q == PH_XSEEN) |-> count_q != '0)
		else $error("prefix phase with nothing consumed");

endmodule

// ----- tb/ttoi_checker.sv -----
// Checker for the text-to-integer parser: predicts each result from the accepted beats.
module ttoi_checker
	import ttoi_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	ttoi_cfg_if    cfg,
	ttoi_in_if     chars,
	ttoi_out_if    result,
	output int     mismatches = 0,
	output int     outstanding = 0,
	output int     results_seen = 0
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [6:0] NOT_A_DIGIT = 7'd99;

	typedef enum logic [2:0] {
		ST_DONE,
		ST_LEAD,
		ST_SIGN,
		ST_ZERO,
		ST_PREFIX,
		ST_DIGITS
	} parse_state_t;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value;
		logic [COUNT_WIDTH-1:0] end_offset;
		logic                   bad_base;
		logic                   overflow;
	} parse_result_t;

	parse_result_t          expected_q[$];
	logic [RADIX_WIDTH-1:0] radix_q = RADIX_RESET;
	parse_state_t           state = ST_DONE;
	logic                   minus;
	logic [VALUE_WIDTH-1:0] acc;
	logic [RADIX_WIDTH-1:0] base;
	logic [COUNT_WIDTH-1:0] used;
	logic                   ovf;

	function automatic logic is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic [6:0] digit_value(input logic [7:0] c);
		if (c >= CH_0 && c <= CH_9)
			return 7'(c - CH_0);
		if (c >= CH_LA && c <= CH_LZ)
			return 7'(c - CH_LA) + 7'(LETTER_OFFSET);
		if (c >= CH_UA && c <= CH_UZ)
			return 7'(c - CH_UA) + 7'(LETTER_OFFSET);
		return NOT_A_DIGIT;
	endfunction

	task automatic bump_count();
		if (used != COUNT_MAX)
			used = used + 1'b1;
	endtask

	task automatic emit_result(input logic [63:0] v, input logic [15:0] e,
			input logic bad, input logic of);
		parse_result_t r;
		r.value      = v;
		r.end_offset = e;
		r.bad_base   = bad;
		r.overflow   = of;
		expected_q.push_back(r);
		state = ST_DONE;
	endtask

	task automatic take_digit(input logic [7:0] c);
		logic [6:0]  d;
		logic [69:0] prod;
		d = digit_value(c);
		if (d < 7'(base)) begin
			prod = 70'(acc) * 70'(base) + 70'(d);
			if (prod[69:64] != '0)
				ovf = 1'b1;
			acc = prod[63:0];
			bump_count();
			state = ST_DIGITS;
		end else if (state != ST_DIGITS) begin
			emit_result('0, '0, 1'b0, 1'b0);
		end else begin
			emit_result(minus ? -acc : acc, used, 1'b0, ovf);
		end
	endtask

	task automatic open_number(input logic [7:0] c);
		if (base == BASE_ONE || base > BASE_MAX) begin
			emit_result('0, '0, 1'b1, 1'b0);
		end else if (c == CH_0 && (base == BASE_AUTO || base == BASE_HEX)) begin
			bump_count();
			state = ST_ZERO;
		end else begin
			if (base == BASE_AUTO)
				base = BASE_DEC;
			take_digit(c);
		end
	endtask

	task automatic step_parser(input logic [7:0] c, input logic restart);
		if (restart) begin
			state = ST_LEAD;
			minus = 1'b0;
			acc   = '0;
			base  = radix_q;
			used  = '0;
			ovf   = 1'b0;
		end
		case (state)
			ST_LEAD: begin
				if (is_space(c)) begin
					bump_count();
				end else if (c == CH_PLUS || c == CH_MINUS) begin
					minus = (c == CH_MINUS);
					bump_count();
					state = ST_SIGN;
				end else begin
					open_number(c);
				end
			end
			ST_SIGN: open_number(c);
			ST_ZERO: begin
				if (c == CH_LX || c == CH_UX) begin
					bump_count();
					base  = BASE_HEX;
					state = ST_PREFIX;
				end else begin
					if (base == BASE_AUTO)
						base = BASE_OCT;
					state = ST_DIGITS;
					take_digit(c);
				end
			end
			ST_PREFIX: begin
				// "0x" with no hex digit after it: only the zero counts
				if (digit_value(c) < 7'(BASE_HEX)) begin
					state = ST_DIGITS;
					take_digit(c);
				end else begin
					emit_result('0, (used == COUNT_MAX) ? COUNT_MAX : used - 1'b1, 1'b0, 1'b0);
				end
			end
			ST_DIGITS: take_digit(c);
			default: state = ST_DONE;
		endcase
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $time, field, got, want);
		mismatches++;
	endtask

	always @(posedge clk) begin
		parse_result_t want;
		if (!arst_n) begin
			radix_q = RADIX_RESET;
			state   = ST_DONE;
			minus   = 1'b0;
			acc     = '0;
			base    = '0;
			used    = '0;
			ovf     = 1'b0;
			expected_q.delete();
		end else begin
			// compare before predicting: a result never belongs to a beat of the same edge
			if (result.valid && result.ready) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					report_mismatch("value (no result expected)", result.value, '0);
				end else begin
					want = expected_q.pop_front();
					if (result.value !== want.value)
						report_mismatch("value", result.value, want.value);
					if (result.end_offset !== want.end_offset)
						report_mismatch("end_offset", 64'(result.end_offset),
							64'(want.end_offset));
					if (result.bad_base !== want.bad_base)
						report_mismatch("bad_base", 64'(result.bad_base), 64'(want.bad_base));
					if (result.overflow !== want.overflow)
						report_mismatch("overflow", 64'(result.overflow), 64'(want.overflow));
				end
			end
			if (cfg.valid && cfg.ready)
				radix_q = cfg.radix;
			if (chars.valid && chars.ready)
				step_parser(chars.ch, chars.first);
		end
		outstanding = expected_q.size();
	end

endmodule

// ----- tb/tb_top.sv -----
// Top of the parser testbench: clock, reset, character stimulus, result sink and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ttoi_pkg::*;

	localparam int HOLD_CYCLES    = 200;
	localparam int SETTLE_CYCLES  = 4;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_ITEMS    = 22;
	localparam int PHASES         = 12;

	logic clk;
	logic arst_n;

	int   mismatches;
	int   outstanding;
	int   results_seen;
	int   chars_sent = 0;
	int   radix_writes = 0;
	int   holds_done = 0;
	int   idle_cycles;
	bit   quiet_in = 0;
	bit   quiet_out = 0;
	bit   hold_req = 0;

	logic [RADIX_WIDTH-1:0] radix_plan[10] = '{
		BASE_AUTO, 6'd2, BASE_MAX, BASE_HEX, BASE_OCT, BASE_DEC, BASE_ONE, 6'd63, 6'd37, 6'd3
	};

	ttoi_cfg_if cfg_ch();
	ttoi_in_if  in_ch();
	ttoi_out_if res_ch();

	text_to_integer_parser u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.chars  (in_ch),
		.result (res_ch)
	);

	ttoi_checker u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_ch),
		.chars        (in_ch),
		.result       (res_ch),
		.mismatches   (mismatches),
		.outstanding  (outstanding),
		.results_seen (results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [7:0] digit_char(input int d);
		if (d < 10)
			return 8'(CH_0 + d);
		return 8'(($urandom_range(0, 1) ? CH_LA : CH_UA) + d - 10);
	endfunction

	task automatic put_char(input logic [7:0] c, input logic fresh);
		int gap;
		gap = quiet_in ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.ch    <= c;
		in_ch.first <= fresh;
		do @(posedge clk); while (!in_ch.ready);
		chars_sent++;
	endtask

	task automatic put_text(input string s, input bit fresh, input bit terminate);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i], fresh && i == 0);
		if (terminate)
			put_char(8'h00, fresh && s.len() == 0);
	endtask

	task automatic send_bytes(input logic [7:0] q[$]);
		foreach (q[i])
			put_char(q[i], i == 0);
	endtask

	task automatic set_radix(input logic [RADIX_WIDTH-1:0] r);
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		// let a string that produced no result drain through the pipeline
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.radix <= r;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		radix_writes++;
	endtask

	task automatic send_number(input logic [RADIX_WIDTH-1:0] r);
		logic [7:0] q[$];
		int         b;
		int         n;
		b = (r >= 2 && r <= BASE_MAX) ? int'(r) : 36;
		repeat ($urandom_range(0, 3))
			q.push_back($urandom_range(0, 5) == 0 ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR)));
		case ($urandom_range(0, 2))
			1: q.push_back(CH_PLUS);
			2: q.push_back(CH_MINUS);
			default: ;
		endcase
		if (r == BASE_AUTO) begin
			case ($urandom_range(0, 2))
				0: begin
					q.push_back(CH_0);
					q.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
					b = 16;
				end
				1: begin
					q.push_back(CH_0);
					b = 8;
				end
				default: b = 10;
			endcase
		end else if (r == BASE_HEX && $urandom_range(0, 1)) begin
			q.push_back(CH_0);
			q.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
		end
		// now and then a long run that can wrap the 64-bit accumulator
		if ($urandom_range(0, 7) == 0)
			n = (b <= 4) ? $urandom_range(30, 70) : $urandom_range(14, 26);
		else
			n = $urandom_range(0, 6);
		repeat (n) q.push_back(digit_char($urandom_range(0, b - 1)));
		case ($urandom_range(0, 5))
			0, 1, 2: q.push_back(8'h00);
			3: q.push_back(8'($urandom_range(0, 255)));
			4: q.push_back(8'($urandom_range(128, 255)));
			default: ;   // leave the string open: the next first restarts the parse
		endcase
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3)) q.push_back(8'($urandom_range(0, 255)));
		send_bytes(q);
	endtask

	task automatic send_noise();
		logic [7:0] q[$];
		repeat ($urandom_range(1, 6)) q.push_back(8'($urandom_range(0, 255)));
		send_bytes(q);
	endtask

	// result sink: random stalls, one long hold-off on request
	initial begin
		int stall;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (hold_req) begin
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 0;
				holds_done++;
			end
			stall = quiet_out ? 0 : $urandom_range(0, 5);
			if (stall != 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Timed out after %0d cycles with no beat", WATCHDOG_LIMIT);
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		logic [RADIX_WIDTH-1:0] r;
		int                     phase_start;
		arst_n       = 1'b0;
		in_ch.valid  = 1'b0;
		in_ch.ch     = '0;
		in_ch.first  = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.radix = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// radix 10 out of reset
		put_char(CH_9, 1'b0);           // no first yet: dropped
		put_text("\t-42x z", 1, 0);     // trailing characters after the stop are dropped
		put_text("+", 1, 1);            // sign with no digits
		put_text("", 1, 1);             // empty string
		put_char(8'hFF, 1'b1);          // top code: not a digit

		set_radix(BASE_AUTO);
		put_text("0x1f", 1, 1);
		put_text("0xg", 1, 0);          // prefix with no hex digit
		put_text("017", 1, 1);

		set_radix(BASE_ONE);
		put_text("-5", 1, 0);           // invalid base reported after the sign

		for (int p = 0; p < PHASES; p++) begin
			r = (p < 10) ? radix_plan[p] : RADIX_WIDTH'($urandom_range(0, 40));
			quiet_in  = (p % 4 == 1);
			quiet_out = (p % 4 == 1);
			set_radix(r);
			phase_start = chars_sent;
			while (chars_sent - phase_start < PHASE_ITEMS) begin
				if ($urandom_range(0, 4) == 0)
					send_noise();
				else
					send_number(r);
			end
		end
		quiet_out = 0;

		// hold the sink while short strings keep coming, so the input backs up
		set_radix(BASE_DEC);
		hold_req = 1;
		quiet_in = 1;
		repeat (40) begin
			put_char(digit_char($urandom_range(0, 9)), 1'b1);
			put_char(8'h00, 1'b0);
		end
		quiet_in = 0;

		in_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (10) @(posedge clk);

		$display("Sent %0d characters under %0d radix writes; checked %0d results.",
			chars_sent, radix_writes, results_seen);
		$display("Covered invalid bases, prefixes, wrapping runs and %0d long sink hold.",
			holds_done);
		if (mismatches == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/ttoi_pkg.sv
rtl/ttoi_if.sv
rtl/ttoi_classify.sv
rtl/ttoi_mac.sv
rtl/text_to_integer_parser.sv
tb/ttoi_checker.sv
tb/tb_top.sv
